>>> rtl/gdpf_pkg.sv
// ----------------------------------------------------------------------------
// gdpf_pkg
// Shared types and constants of the dual-protocol GNSS framer: framing
// states, register indexes, register reset values and stream field layout.
// ----------------------------------------------------------------------------
package gdpf_pkg;

  // framing state, one-hot
  typedef enum logic [2:0] {
    MODE_IDLE   = 3'b001,
    MODE_TEXT   = 3'b010,
    MODE_BINARY = 3'b100
  } mode_t;

  // configuration register indexes
  localparam int unsigned CFG_ADDR_W = 2;
  localparam logic [CFG_ADDR_W-1:0] REG_TEXT_START  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_TEXT_END    = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_SYNC_FIRST  = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_SYNC_SECOND = 2'd3;

  // register reset values
  localparam logic [7:0] TEXT_START_RST  = 8'd36;
  localparam logic [7:0] TEXT_END_RST    = 8'd10;
  localparam logic [7:0] SYNC_FIRST_RST  = 8'd181;
  localparam logic [7:0] SYNC_SECOND_RST = 8'd98;

  // binary frame length field sits in positions 4 and 5
  localparam logic [7:0]  LEN_LOW_DONE_POS = 8'd6;
  localparam logic [15:0] BINARY_OVERHEAD  = 16'd8;

  // stream widths and result field offsets in out_tdata
  localparam int unsigned IN_TDATA_W    = 8;
  localparam int unsigned OUT_TDATA_W   = 32;
  localparam int unsigned OUT_WE_BIT    = 0;
  localparam int unsigned OUT_BANK_BIT  = 1;
  localparam int unsigned OUT_INDEX_LSB = 2;
  localparam int unsigned OUT_DATA_LSB  = 10;
  localparam int unsigned OUT_LEN_LSB   = 18;

endpackage

>>> rtl/gnss_dual_protocol_framer_core.sv
// ----------------------------------------------------------------------------
// gnss_dual_protocol_framer_core
// Frames text sentences and binary sync-led frames from a received byte
// stream into two alternating frame buffers.
// ----------------------------------------------------------------------------
// One item in, one item out: every received byte gives one result that names
// the bank and position where it goes, or marks it dropped on overflow, and
// flags the byte that completes a frame with its kind and length. The
// framing state is updated in the cycle a byte is accepted and the result is
// held in one output register, so a byte can be taken every clock while
// out_tready keeps up; results appear in the cycle after acceptance. in_tready
// falls only while a result waits and out_tready is low. Configuration writes
// are taken at any time but belong only in idle periods.
module gnss_dual_protocol_framer_core #(
  parameter int unsigned BUFFER_BYTES = 128
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // configuration
  input  logic                             cfg_we,
  input  logic [gdpf_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [7:0]                       cfg_wdata,
  // received bytes
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [gdpf_pkg::IN_TDATA_W-1:0]  in_tdata,   // [7:0] rx_byte
  // results
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [0] write_enable, [1] write_bank, [9:2] write_index, [17:10] data_byte,
  // [25:18] frame_length, [31:26] zero
  output logic [gdpf_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                             out_tlast,  // frame_done
  output logic                             out_tuser   // [0] frame_kind
);
  import gdpf_pkg::*;

  localparam logic [7:0] BufLimit = 8'(BUFFER_BYTES);

  // configuration registers
  logic [7:0] text_start_r, text_end_r, sync_first_r, sync_second_r;

  // framing state
  logic [7:0]  pos_r, pos_nxt;
  logic [7:0]  last_r, last_nxt;
  mode_t       mode_r, mode_nxt;
  logic [15:0] end_r, end_nxt;
  logic        bank_r, bank_nxt;

  // result register
  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;
  logic                   out_last_r, out_last_nxt;
  logic                   out_user_r, out_user_nxt;

  logic        in_acc;
  logic [7:0]  rx;
  logic        text_start, sync_start, ovf, bin_done, txt_done, done;
  mode_t       mode1;
  logic [7:0]  pos1, pos2;
  logic [15:0] end1, end2;

  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;
  assign rx        = in_tdata[7:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_start_r  <= TEXT_START_RST;
      text_end_r    <= TEXT_END_RST;
      sync_first_r  <= SYNC_FIRST_RST;
      sync_second_r <= SYNC_SECOND_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_TEXT_START:  text_start_r  <= cfg_wdata;
        REG_TEXT_END:    text_end_r    <= cfg_wdata;
        REG_SYNC_FIRST:  sync_first_r  <= cfg_wdata;
        REG_SYNC_SECOND: sync_second_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    // frame starts: text start is plain payload inside a binary frame
    text_start = (rx == text_start_r) && (mode_r != MODE_BINARY);
    sync_start = !text_start && (last_r == sync_first_r) &&
                 (rx == sync_second_r) && (mode_r == MODE_IDLE);

    mode1 = mode_r;
    pos1  = pos_r;
    end1  = end_r;
    if (text_start) begin
      mode1 = MODE_TEXT;
      pos1  = 8'd0;
    end else if (sync_start) begin
      mode1 = MODE_BINARY;
      pos1  = 8'd1;
      end1  = 16'd0;
    end

    ovf  = (pos1 >= BufLimit);
    pos2 = pos1 + 8'd1;

    end2 = end1;
    if (mode1 == MODE_BINARY && pos2 == LEN_LOW_DONE_POS) begin
      end2 = {rx, last_r} + BINARY_OVERHEAD;
    end

    bin_done = !ovf && (mode1 == MODE_BINARY) && (end2 == {8'd0, pos2});
    txt_done = !ovf && !bin_done && (rx == text_end_r) && (mode1 == MODE_TEXT);
    done     = bin_done || txt_done;

    if (ovf) begin
      // byte dropped, open frame carries on from position 0
      pos_nxt  = 8'd0;
      mode_nxt = mode1;
      end_nxt  = end1;
      bank_nxt = bank_r;
      last_nxt = last_r;
    end else begin
      pos_nxt  = done ? 8'd0 : pos2;
      mode_nxt = done ? MODE_IDLE : mode1;
      end_nxt  = end2;
      bank_nxt = bank_r ^ done;
      last_nxt = rx;
    end

    out_data_nxt                            = '0;
    out_data_nxt[OUT_WE_BIT]                = !ovf;
    out_data_nxt[OUT_BANK_BIT]              = bank_r;
    out_data_nxt[OUT_INDEX_LSB +: 8]        = ovf ? 8'd0 : pos1;
    out_data_nxt[OUT_DATA_LSB +: 8]         = rx;
    // both kinds end with the frame length equal to the next position
    out_data_nxt[OUT_LEN_LSB +: 8]          = done ? pos2 : 8'd0;
    out_last_nxt                            = done;
    out_user_nxt                            = bin_done;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= 8'd0;
      last_r <= 8'd0;
      mode_r <= MODE_IDLE;
      end_r  <= 16'd0;
      bank_r <= 1'b0;
    end else if (in_acc) begin
      pos_r  <= pos_nxt;
      last_r <= last_nxt;
      mode_r <= mode_nxt;
      end_r  <= end_nxt;
      bank_r <= bank_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_tready) begin
      out_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_data_r <= out_data_nxt;
      out_last_r <= out_last_nxt;
      out_user_r <= out_user_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_user_r;

endmodule

>>> rtl/gdpf_checker.sv
// ----------------------------------------------------------------------------
// gdpf_checker
// Port-level checks of the framer's result stream.
// ----------------------------------------------------------------------------
module gdpf_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [gdpf_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                             out_tlast,
  input logic                             out_tuser
);
  import gdpf_pkg::*;

  logic       we;
  logic [7:0] idx, flen;

  assign we   = out_tdata[OUT_WE_BIT];
  assign idx  = out_tdata[OUT_INDEX_LSB +: 8];
  assign flen = out_tdata[OUT_LEN_LSB +: 8];

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
    $stable(out_tlast) && $stable(out_tuser))
    else $error("result changed while stalled");

  // a dropped byte never completes a frame and reports position 0
  a_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !we |-> !out_tlast && !out_tuser && idx == 8'd0)
    else $error("dropped byte reported as stored or completing");

  // a completed frame covers every position up to the last byte
  a_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> flen == idx + 8'd1)
    else $error("frame length does not match last position");

  // no kind or length without completion
  a_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !out_tuser && flen == 8'd0)
    else $error("kind or length set without completion");

  // an accepted byte always shows a result in the next cycle
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("accepted byte gave no result");

endmodule

bind gnss_dual_protocol_framer_core gdpf_checker u_gdpf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);
